[rtl/nts_pkg.sv]
// shared types and constants for the note table step sequencer
// no dependencies; used by the channel interfaces, the note memory and the top level
package nts_pkg;

  localparam int NOTE_DEPTH_DEF = 64;

  localparam int PITCH_W  = 7;
  localparam int LENGTH_W = 32;
  localparam int AMP_W    = 15;
  localparam int LEVEL_W  = 16;
  localparam int STEP_W   = 24;
  localparam int GAIN_W   = 16;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN = 2'd1;

  localparam logic [STEP_W-1:0] TICK_STEP_RST   = 24'd350;
  localparam logic [GAIN_W-1:0] MASTER_GAIN_RST = 16'd4915;

  typedef struct packed {
    logic [PITCH_W-1:0]  pitch;
    logic [LENGTH_W-1:0] length;
    logic [AMP_W-1:0]    amp;
  } note_t;

endpackage

[rtl/nts_channels.sv]
// valid/ready channel interfaces: command words in, result words out, register writes
// depends on nts_pkg for field widths
interface nts_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [nts_pkg::CMD_W-1:0]            command;
  logic [nts_pkg::PITCH_W-1:0]          note_pitch;
  logic [nts_pkg::LENGTH_W-1:0]         note_length;
  logic [nts_pkg::AMP_W-1:0]            note_amplitude;
  modport source (output valid, command, note_pitch, note_length, note_amplitude,
                  input ready);
  modport sink (input valid, command, note_pitch, note_length, note_amplitude,
                output ready);
endinterface

interface nts_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [nts_pkg::PITCH_W-1:0]          pitch_out;
  logic signed [nts_pkg::LEVEL_W-1:0]   level_out;
  logic                                 sounding;
  modport source (output valid, pitch_out, level_out, sounding, input ready);
  modport sink (input valid, pitch_out, level_out, sounding, output ready);
endinterface

interface nts_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [nts_pkg::CFG_IDX_W-1:0]        index;
  logic [nts_pkg::CFG_DATA_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/note_table_step_sequencer_core.sv]
// top level of the note table step sequencer: command decode, table walk, level scaling
// depends on nts_pkg, the channel interfaces and nts_note_mem
//
//   channel | dir | word
//   req     | in  | command, note_pitch, note_length, note_amplitude
//   rsp     | out | pitch_out, level_out, sounding (one word per tick command)
//   cfg     | in  | index, data (0 tick_step, 1 master_gain)
//
// add, restart and clear give no word
// a tick walks the table from entry 0 to the first note that holds the time, scales
// that note's amplitude by master_gain if there is one, then gives its word; the walk
// reads one table entry per cycle from the memory port
// a finished word waits in the output register; the next command is taken meanwhile,
// and a following tick stalls only at its own delivery
// rst is synchronous: it clears count, play time and held pitch and resets the registers;
// the table itself is not cleared
module note_table_step_sequencer_core #(
  parameter int NOTE_DEPTH = nts_pkg::NOTE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  nts_req_if.sink       req,
  nts_rsp_if.source     rsp,
  nts_cfg_if.sink       cfg
);

  localparam int AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
  localparam int CW = $clog2(NOTE_DEPTH + 1);
  localparam int SW = nts_pkg::LENGTH_W + CW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_SCALE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                          state;
  logic [CW-1:0]                       note_count;
  logic [nts_pkg::LENGTH_W-1:0]        play_time;
  logic [nts_pkg::PITCH_W-1:0]         held_pitch;
  logic [nts_pkg::STEP_W-1:0]          tick_step;
  logic signed [nts_pkg::GAIN_W-1:0]   master_gain;

  logic [CW-1:0]                       issue_idx;
  logic                                pend;
  logic [SW-1:0]                       start;
  logic                                hit;
  logic [nts_pkg::AMP_W-1:0]           hit_amp;
  logic signed [30:0]                  prod;

  nts_pkg::note_t                      wr_note;
  nts_pkg::note_t                      rd_note;
  logic                                mem_we;

  logic                                req_fire;
  logic                                out_free;
  logic [nts_pkg::LENGTH_W:0]          time_sum;
  logic [SW-1:0]                       span_end;
  logic                                issue_ok;
  logic                                span_hit;
  logic signed [31:0]                  prod_full;
  logic signed [31:0]                  prod_rnd;
  logic signed [17:0]                  level_wide;
  logic signed [nts_pkg::LEVEL_W-1:0]  level_sat;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;

  assign wr_note.pitch  = req.note_pitch;
  assign wr_note.length = req.note_length;
  assign wr_note.amp    = req.note_amplitude;
  assign mem_we = req_fire && (req.command == nts_pkg::CMD_ADD)
                  && (note_count < CW'(NOTE_DEPTH));

  nts_note_mem #(
    .DEPTH (NOTE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (note_count[AW-1:0]),
    .wdata (wr_note),
    .raddr (issue_idx[AW-1:0]),
    .rdata (rd_note)
  );

  assign time_sum = {1'b0, play_time} + {{(nts_pkg::LENGTH_W - nts_pkg::STEP_W + 1){1'b0}},
                                         tick_step};
  assign issue_ok = issue_idx < note_count;
  assign span_end = start + {{CW{1'b0}}, rd_note.length};
  // start never passes the time while walking, so only the end needs a compare
  assign span_hit = pend && (span_end > {{CW{1'b0}}, play_time});

  assign prod_full  = $signed({1'b0, hit_amp}) * master_gain;
  assign prod_rnd   = {prod[30], prod} + 32'sd8192;
  assign level_wide = prod_rnd[31:14];

  always_comb begin
    if (level_wide > 18'sd32767) begin
      level_sat = 16'sh7fff;
    end else if (level_wide < -18'sd32768) begin
      level_sat = -16'sh8000;
    end else begin
      level_sat = level_wide[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step   <= nts_pkg::TICK_STEP_RST;
      master_gain <= nts_pkg::MASTER_GAIN_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        nts_pkg::REG_TICK_STEP:   tick_step   <= cfg.data[nts_pkg::STEP_W-1:0];
        nts_pkg::REG_MASTER_GAIN: master_gain <= cfg.data[nts_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      note_count <= '0;
      play_time  <= '0;
      held_pitch <= '0;
      pend       <= 1'b0;
      hit        <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      // a new word loaded in the done state replaces the one taken this cycle
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            unique case (req.command)
              nts_pkg::CMD_TICK: begin
                // saturate the play time at the top of its range
                play_time <= time_sum[nts_pkg::LENGTH_W] ? '1
                                                         : time_sum[nts_pkg::LENGTH_W-1:0];
                issue_idx <= '0;
                start     <= '0;
                pend      <= 1'b0;
                hit       <= 1'b0;
                state     <= S_WALK;
              end
              nts_pkg::CMD_ADD: begin
                if (mem_we) begin
                  note_count <= note_count + 1'b1;
                end
              end
              nts_pkg::CMD_RESTART: play_time <= '0;
              nts_pkg::CMD_CLEAR: begin
                play_time  <= '0;
                note_count <= '0;
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (span_hit) begin
            held_pitch <= rd_note.pitch;
            hit_amp    <= rd_note.amp;
            hit        <= 1'b1;
            pend       <= 1'b0;
            state      <= S_SCALE;
          end else begin
            if (pend) begin
              start <= span_end;
            end
            // read of the next entry overlaps the check of the current one
            if (issue_ok) begin
              issue_idx <= issue_idx + 1'b1;
              pend      <= 1'b1;
            end else begin
              pend <= 1'b0;
              if (!pend) begin
                state <= S_DONE;
              end
            end
          end
        end
        S_SCALE: begin
          prod  <= prod_full[30:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp.valid     <= 1'b1;
            rsp.pitch_out <= held_pitch;
            rsp.level_out <= hit ? level_sat : '0;
            rsp.sounding  <= hit;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) note_count <= CW'(NOTE_DEPTH))
    else $error("note count beyond table depth");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (issue_idx <= note_count))
    else $error("table walk past the valid entries");

  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.sounding |-> (rsp.level_out == '0))
    else $error("silent word with nonzero level");

  assert property (@(posedge clk) disable iff (rst)
    req_fire && (req.command == nts_pkg::CMD_TICK) |=> !req.ready)
    else $error("tick did not start a walk");

endmodule

[rtl/nts_note_mem.sv]
// note table storage: one write port, one read port with registered read data
// depends on nts_pkg for the note entry type
module nts_note_mem #(
  parameter int DEPTH = nts_pkg::NOTE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  nts_pkg::note_t wdata,
  input  logic [AW-1:0]  raddr,
  output nts_pkg::note_t rdata
);

  nts_pkg::note_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
